FILE: hw/rtl/adb_host_connection_manager_macros.svh
// ============================================================================
// Assertion macros for the debug-bridge host connection manager
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef ADB_HOST_CONNECTION_MANAGER_MACROS_SVH
`define ADB_HOST_CONNECTION_MANAGER_MACROS_SVH

// same-cycle implication
`define AHCM_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define AHCM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/ahcm_pkg.sv
// ============================================================================
// ahcm_pkg
// Types, codes and constants of the debug-bridge host connection manager.
// ============================================================================
package ahcm_pkg;

  localparam int DEF_MAX_SLOTS = 2;
  localparam int RES_DEPTH     = 4;
  localparam int RES_IW        = 2;
  localparam int RES_CW        = 3;

  localparam logic [31:0] CNXN_VERSION    = 32'h0100_0000;
  localparam logic [31:0] CNXN_MAXDATA    = 32'd4096;
  localparam logic [15:0] CNXN_BANNER_LEN = 16'd18;
  localparam logic [15:0] CONNECT_CAP     = 16'd256;
  localparam logic [31:0] RETRY_RESET     = 32'd1000;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_MSG    = 3'd1,
    OP_ATTACH = 3'd2,
    OP_DETACH = 3'd3,
    OP_WRITE  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_CNXN = 3'd0,
    CMD_OPEN = 3'd1,
    CMD_OKAY = 3'd2,
    CMD_CLSE = 3'd3,
    CMD_WRTE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    EV_CONNECT = 3'd0,
    EV_OPENED  = 3'd1,
    EV_FAILED  = 3'd2,
    EV_CLOSED  = 3'd3,
    EV_RECEIVE = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_EVENT  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    WS_ACCEPTED = 2'd0,
    WS_NO_LINK  = 2'd1,
    WS_NOT_OPEN = 2'd2
  } wstatus_t;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_OPENING = 3'd2,
    ST_OPEN    = 3'd3,
    ST_WRITING = 3'd4
  } slot_st_t;

  typedef enum logic [1:0] {
    CFG_SLOT_ENABLE    = 2'd0,
    CFG_RECONNECT_MASK = 2'd1,
    CFG_RETRY_MS       = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cmd;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [15:0] plen;
    logic [2:0]  ev;
    logic        slot;
    logic [1:0]  ws;
  } res_t;

endpackage

FILE: hw/rtl/adb_host_connection_manager.sv
// ============================================================================
// adb_host_connection_manager
// Host-side debug-bridge link manager over a small table of connection slots.
// ============================================================================
// One item at a time: in_ready is high only while idle. Once attached, a tick
// or received header polls the slots (only the link while it is down; else
// one slot per cycle through a shared 32-bit subtract and compare against
// retry_ms), a header then adds a connect step, a slot dispatch and a step
// per data-received event, a detach visits every slot, a write request is
// checked and, if open, sent; then each result (at most four, later ones
// dropped) is handed out as one beat per cycle while out_ready is high, the
// last flagged by out_last. Configuration is taken only while idle.
module adb_host_connection_manager
  import ahcm_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [2:0]  in_msg_command,
  input  logic [31:0] in_msg_arg0,
  input  logic [31:0] in_msg_arg1,
  input  logic [15:0] in_msg_length,
  input  logic [31:0] in_now_ms,
  input  logic        in_write_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_command,
  output logic [31:0] out_arg0,
  output logic [31:0] out_arg1,
  output logic [15:0] out_payload_length,
  output logic [2:0]  out_event_type,
  output logic        out_slot,
  output logic [1:0]  out_write_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(MAX_SLOTS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POLL   = 7'b0000010,
    S_CNXN   = 7'b0000100,
    S_MSG    = 7'b0001000,
    S_DETACH = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_DRAIN  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SLOT_IW-1:0]   idx_r, idx_nxt;
  logic                 sub_r, sub_nxt;
  logic [RES_CW-1:0]    cnt_r, cnt_nxt;
  logic [RES_IW-1:0]    rd_r, rd_nxt;
  logic                 device_r, device_nxt;
  logic                 link_r, link_nxt;
  logic [1:0]           reconnect_r, reconnect_nxt;
  logic [31:0]          retry_r, retry_nxt;
  slot_st_t             status_r [MAX_SLOTS];
  slot_st_t             status_nxt [MAX_SLOTS];
  logic [31:0]          remote_r [MAX_SLOTS];
  logic [31:0]          remote_nxt [MAX_SLOTS];
  logic [31:0]          attempt_r [MAX_SLOTS];
  logic [31:0]          attempt_nxt [MAX_SLOTS];

  logic [2:0]           opcode_r;
  logic [2:0]           cmd_r;
  logic [31:0]          arg0_r;
  logic [31:0]          arg1_r;
  logic [15:0]          len_r;
  logic [31:0]          now_r;
  logic                 ws_r;
  res_t                 res_buf_r [RES_DEPTH];

  logic                 in_beat, out_beat, cfg_beat;
  logic                 push_en, push_ok, done;
  res_t                 push_res, out_res;
  slot_st_t             cur_st;
  logic [31:0]          elapsed;
  logic                 retry_due;
  logic                 slot_match;
  logic                 ws_ok;
  logic [MAX_SLOTS-1:0] en_vec, rc_vec;
  logic [31:0]          slot_id;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DRAIN) && (cnt_r != '0);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign cfg_beat  = cfg_valid && cfg_ready;

  assign cur_st     = status_r[idx_r];
  assign elapsed    = now_r - attempt_r[idx_r];
  assign retry_due  = elapsed > retry_r;
  assign slot_id    = 32'(idx_r) + 32'd1;
  assign slot_match = (cur_st != ST_UNUSED) && (slot_id == arg1_r);
  assign ws_ok      = 32'(in_write_slot) < 32'(MAX_SLOTS);
  assign en_vec     = MAX_SLOTS'(cfg_wdata[1:0]);
  assign rc_vec     = MAX_SLOTS'(reconnect_r);

  assign out_res            = res_buf_r[rd_r];
  assign out_result_kind    = out_res.kind;
  assign out_command        = out_res.cmd;
  assign out_arg0           = out_res.arg0;
  assign out_arg1           = out_res.arg1;
  assign out_payload_length = out_res.plen;
  assign out_event_type     = out_res.ev;
  assign out_slot           = out_res.slot;
  assign out_write_status   = out_res.ws;
  assign out_last           = ((RES_CW'(rd_r) + RES_CW'(1)) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    device_nxt    = device_r;
    link_nxt      = link_r;
    reconnect_nxt = reconnect_r;
    retry_nxt     = retry_r;
    status_nxt    = status_r;
    remote_nxt    = remote_r;
    attempt_nxt   = attempt_r;
    push_en       = 1'b0;
    push_res      = '0;
    done          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          idx_nxt = '0;
          sub_nxt = 1'b0;
          case (in_opcode)
            OP_TICK, OP_MSG: begin
              if (device_r) begin
                state_nxt = S_POLL;
              end
            end
            OP_ATTACH: begin
              device_nxt = 1'b1;
            end
            OP_DETACH: begin
              if (device_r) begin
                state_nxt = S_DETACH;
              end
            end
            OP_WRITE: begin
              state_nxt = S_WRITE;
              if (ws_ok) begin
                idx_nxt = SLOT_IW'(in_write_slot);
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
        if (cfg_beat) begin
          case (cfg_index)
            CFG_SLOT_ENABLE: begin
              for (int i = 0; i < MAX_SLOTS; i++) begin
                if (en_vec[i] && (status_r[i] == ST_UNUSED)) begin
                  status_nxt[i]  = ST_CLOSED;
                  attempt_nxt[i] = '0;
                end
              end
            end
            CFG_RECONNECT_MASK: reconnect_nxt = cfg_wdata[1:0];
            CFG_RETRY_MS:       retry_nxt     = cfg_wdata;
            default:            reconnect_nxt = reconnect_r;
          endcase
        end
      end

      S_POLL: begin
        if (!link_r) begin
          push_en       = 1'b1;
          push_res.kind = KIND_HEADER;
          push_res.cmd  = CMD_CNXN;
          push_res.arg0 = CNXN_VERSION;
          push_res.arg1 = CNXN_MAXDATA;
          push_res.plen = CNXN_BANNER_LEN;
        end else if ((cur_st == ST_CLOSED) && retry_due) begin
          push_en            = 1'b1;
          push_res.kind      = KIND_HEADER;
          push_res.cmd       = CMD_OPEN;
          push_res.arg0      = slot_id;
          attempt_nxt[idx_r] = now_r;
          status_nxt[idx_r]  = ST_OPENING;
        end
        if (!link_r || (idx_r == LAST_SLOT)) begin
          idx_nxt = '0;
          if (opcode_r == OP_MSG) begin
            state_nxt = S_CNXN;
          end else begin
            done = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + SLOT_IW'(1);
        end
      end

      S_CNXN: begin
        if (cmd_r == CMD_CNXN) begin
          link_nxt      = 1'b1;
          push_en       = 1'b1;
          push_res.kind = KIND_EVENT;
          push_res.ev   = EV_CONNECT;
          push_res.plen = (len_r < CONNECT_CAP) ? len_r : CONNECT_CAP;
        end
        state_nxt = S_MSG;
      end

      S_MSG: begin
        if (slot_match) begin
          case (cmd_r)
            CMD_OKAY: begin
              if (cur_st == ST_OPENING) begin
                status_nxt[idx_r] = ST_OPEN;
                remote_nxt[idx_r] = arg0_r;
                push_en           = 1'b1;
                push_res.kind     = KIND_EVENT;
                push_res.ev       = EV_OPENED;
                push_res.arg0     = arg0_r;
                push_res.slot     = idx_r[0];
              end else if (cur_st == ST_WRITING) begin
                status_nxt[idx_r] = ST_OPEN;
              end
            end
            CMD_CLSE: begin
              push_en           = 1'b1;
              push_res.kind     = KIND_EVENT;
              push_res.ev       = (cur_st == ST_OPENING) ? EV_FAILED : EV_CLOSED;
              push_res.slot     = idx_r[0];
              status_nxt[idx_r] = rc_vec[idx_r] ? ST_CLOSED : ST_UNUSED;
            end
            CMD_WRTE: begin
              push_en = 1'b1;
              if ((len_r != '0) && !sub_r) begin
                push_res.kind = KIND_EVENT;
                push_res.ev   = EV_RECEIVE;
                push_res.plen = len_r;
                push_res.slot = idx_r[0];
                sub_nxt       = 1'b1;
              end else begin
                push_res.kind = KIND_HEADER;
                push_res.cmd  = CMD_OKAY;
                push_res.arg0 = arg1_r;
                push_res.arg1 = arg0_r;
                sub_nxt       = 1'b0;
              end
            end
            default: begin
              push_en = 1'b0;
            end
          endcase
        end
        if (!sub_nxt) begin
          if (idx_r == LAST_SLOT) begin
            done = 1'b1;
          end else begin
            idx_nxt = idx_r + SLOT_IW'(1);
          end
        end
      end

      S_DETACH: begin
        if ((cur_st != ST_UNUSED) && (cur_st != ST_CLOSED)) begin
          push_en           = 1'b1;
          push_res.kind     = KIND_EVENT;
          push_res.ev       = (cur_st == ST_OPENING) ? EV_FAILED : EV_CLOSED;
          push_res.slot     = idx_r[0];
          status_nxt[idx_r] = rc_vec[idx_r] ? ST_CLOSED : ST_UNUSED;
        end
        if (idx_r == LAST_SLOT) begin
          device_nxt = 1'b0;
          link_nxt   = 1'b0;
          done       = 1'b1;
        end else begin
          idx_nxt = idx_r + SLOT_IW'(1);
        end
      end

      S_WRITE: begin
        push_en       = 1'b1;
        push_res.kind = KIND_STATUS;
        push_res.slot = ws_r;
        if (sub_r) begin
          push_res.ws = WS_ACCEPTED;
          done        = 1'b1;
        end else if (!device_r || !link_r) begin
          push_res.ws = WS_NO_LINK;
          done        = 1'b1;
        end else if (!(32'(ws_r) < 32'(MAX_SLOTS)) || (cur_st != ST_OPEN)) begin
          push_res.ws = WS_NOT_OPEN;
          done        = 1'b1;
        end else begin
          push_res.kind     = KIND_HEADER;
          push_res.cmd      = CMD_WRTE;
          push_res.arg0     = slot_id;
          push_res.arg1     = remote_r[idx_r];
          push_res.plen     = len_r;
          push_res.slot     = 1'b0;
          status_nxt[idx_r] = ST_WRITING;
          sub_nxt           = 1'b1;
        end
      end

      S_DRAIN: begin
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end else if (out_beat) begin
          if (out_last) begin
            cnt_nxt   = '0;
            rd_nxt    = '0;
            state_nxt = S_IDLE;
          end else begin
            rd_nxt = rd_r + RES_IW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    push_ok = push_en && (cnt_r < RES_CW'(RES_DEPTH));
    if (push_ok) begin
      cnt_nxt = cnt_r + RES_CW'(1);
    end
    if (done) begin
      idx_nxt   = '0;
      sub_nxt   = 1'b0;
      state_nxt = (cnt_nxt == '0) ? S_IDLE : S_DRAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      sub_r       <= 1'b0;
      cnt_r       <= '0;
      rd_r        <= '0;
      device_r    <= 1'b0;
      link_r      <= 1'b0;
      reconnect_r <= '0;
      retry_r     <= RETRY_RESET;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        status_r[i]  <= ST_UNUSED;
        remote_r[i]  <= '0;
        attempt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sub_r       <= sub_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      device_r    <= device_nxt;
      link_r      <= link_nxt;
      reconnect_r <= reconnect_nxt;
      retry_r     <= retry_nxt;
      status_r    <= status_nxt;
      remote_r    <= remote_nxt;
      attempt_r   <= attempt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      opcode_r <= in_opcode;
      cmd_r    <= in_msg_command;
      arg0_r   <= in_msg_arg0;
      arg1_r   <= in_msg_arg1;
      len_r    <= in_msg_length;
      now_r    <= in_now_ms;
      ws_r     <= in_write_slot;
    end
    if (push_ok) begin
      res_buf_r[cnt_r[RES_IW-1:0]] <= push_res;
    end
  end

endmodule

FILE: hw/rtl/ahcm_checker.sv
// ============================================================================
// ahcm_checker
// Port-level checks on the connection manager, bound to its top level.
// ============================================================================
`include "adb_host_connection_manager_macros.svh"

module ahcm_checker
  import ahcm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_arg0,
  input logic [1:0]  out_result_kind,
  input logic        out_last,
  input logic        cfg_ready
);

  `AHCM_ASSERT_NOW(a_no_overlap, out_valid, !in_ready,
    "input taken while results are draining")

  `AHCM_ASSERT_NOW(a_cfg_idle, 1'b1, cfg_ready == in_ready,
    "configuration ready differs from input ready")

  `AHCM_ASSERT_NEXT(a_last_ends, out_valid && out_ready && out_last, !out_valid,
    "result beat after the final one")

  `AHCM_ASSERT_NEXT(a_attach_quiet, in_valid && in_ready && (in_opcode == OP_ATTACH),
    in_ready && !out_valid, "attach produced a result or stalled")

  `AHCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_arg0) && $stable(out_result_kind),
    "stalled result beat changed")

endmodule

bind adb_host_connection_manager ahcm_checker u_ahcm_checker (.*);
